@@ hw/rtl/ssqe_pkg.sv @@
// Shared types and constants for the stock span query engine.
// Used by the cell, chain, controller, top level and checker; depends on nothing.

package ssqe_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int SAMPLE_W    = 16;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = 11;
  localparam int MINUTE_W    = 12;
  localparam int STATUS_W    = 3;

  localparam logic [COUNT_W-1:0]  MAX_RESET = COUNT_W'(1024);
  localparam logic [COUNT_W-1:0]  DEPTH_CNT = COUNT_W'(STORE_DEPTH);
  localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(STORE_DEPTH - 1);
  localparam logic signed [SAMPLE_W-1:0] Q78_HI = SAMPLE_W'(25600);
  localparam logic signed [SAMPLE_W-1:0] Q78_LO = -SAMPLE_W'(25600);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_CORRUPT = 3'd3,
    ST_SPAN    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ROTATE
  } chain_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                       ok;
    logic signed [SAMPLE_W-1:0] value;
  } sample_t;

  typedef struct packed {
    chain_op_t op;
    sample_t   din;
  } chain_ctl_t;

endpackage

@@ hw/rtl/stock_span_query_engine_top.sv @@
// Top level of the stock span query engine: controller plus sample chain.
// Depends on ssqe_pkg, ssqe_ctrl, ssqe_chain.
//
// Input transactions carry kind, sample_value, parse_ok and query_minute and
// are taken on in_valid with in_stall low. Each one yields exactly one result
// transaction (status, span, stored_count) on out_valid with out_stall low.
// A load, a refused load and an out-of-range query are answered in S_IDLE;
// the result appears on the following cycle. For a query inside the store the
// sample ring is rotated once fully past the single read point at cell zero,
// which also restores the sample order. One query is processed at a time;
// loads can be taken every cycle unless a result stalls. The user must write
// max_samples through cfg_wr_en and cfg_wr_data only while the block is idle;
// this is not enforced. Synchronous reset empties the store, restores the
// limit to 1024 and drops out_valid; sample contents are not cleared. While
// the receiver stalls, the result holds and in_stall stays high.

module stock_span_query_engine_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [ssqe_pkg::COUNT_W-1:0]         cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic signed [ssqe_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                 parse_ok,
  input  logic signed [ssqe_pkg::MINUTE_W-1:0] query_minute,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ssqe_pkg::STATUS_W-1:0]        status,
  output logic [ssqe_pkg::COUNT_W-1:0]         span,
  output logic [ssqe_pkg::COUNT_W-1:0]         stored_count
);
  import ssqe_pkg::*;

  chain_ctl_t chain_ctl;
  sample_t    head;

  ssqe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .sample_value (sample_value),
    .parse_ok     (parse_ok),
    .query_minute (query_minute),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .span         (span),
    .stored_count (stored_count),
    .chain_ctl    (chain_ctl),
    .head         (head)
  );

  ssqe_chain u_chain (
    .clk  (clk),
    .ctl  (chain_ctl),
    .head (head)
  );

endmodule

@@ hw/rtl/ssqe_cell.sv @@
// One storage cell of the sample chain: holds a sample and its valid bit.
// Depends on ssqe_pkg for the sample type and the chain operation codes.

module ssqe_cell (
  input  logic               clk,
  input  ssqe_pkg::chain_op_t op,
  input  ssqe_pkg::sample_t  from_lower,
  input  ssqe_pkg::sample_t  from_upper,
  output ssqe_pkg::sample_t  q
);
  import ssqe_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD:   q <= from_lower;
      OP_ROTATE: q <= from_upper;
      default:   q <= q;
    endcase
  end

endmodule

@@ hw/rtl/ssqe_chain.sv @@
// Row of sample cells. A load shifts every sample up by one cell; a rotate
// moves every sample down by one cell around the ring. Depends on ssqe_pkg, ssqe_cell.

module ssqe_chain (
  input  logic                clk,
  input  ssqe_pkg::chain_ctl_t ctl,
  output ssqe_pkg::sample_t   head
);
  import ssqe_pkg::*;

  sample_t cells [STORE_DEPTH];

  for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
    sample_t lower;
    sample_t upper;
    if (k == 0) begin : g_first
      assign lower = ctl.din;
    end else begin : g_rest
      assign lower = cells[k-1];
    end
    if (k == STORE_DEPTH - 1) begin : g_last
      assign upper = cells[0];
    end else begin : g_mid
      assign upper = cells[k+1];
    end
    ssqe_cell u_cell (
      .clk        (clk),
      .op         (ctl.op),
      .from_lower (lower),
      .from_upper (upper),
      .q          (cells[k])
    );
  end

  assign head = cells[0];

endmodule

@@ hw/rtl/ssqe_ctrl.sv @@
// Controller: limit register, sample count, query walk over the rotating chain
// and the result register. Depends on ssqe_pkg.

module ssqe_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ssqe_pkg::COUNT_W-1:0]      cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic signed [ssqe_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                              parse_ok,
  input  logic signed [ssqe_pkg::MINUTE_W-1:0] query_minute,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssqe_pkg::STATUS_W-1:0]     status,
  output logic [ssqe_pkg::COUNT_W-1:0]      span,
  output logic [ssqe_pkg::COUNT_W-1:0]      stored_count,
  output ssqe_pkg::chain_ctl_t              chain_ctl,
  input  ssqe_pkg::sample_t                 head
);
  import ssqe_pkg::*;

  state_t                     state;
  state_t                     state_next;
  logic [COUNT_W-1:0]         max_samples;
  logic [COUNT_W-1:0]         count;
  logic [COUNT_W-1:0]         count_next;
  logic [IDX_W-1:0]           cyc;
  logic [IDX_W-1:0]           skip;
  logic signed [SAMPLE_W-1:0] ref_value;
  logic [COUNT_W-1:0]         span_cnt;
  logic                       alive;
  logic                       corrupt;

  logic                       accept;
  logic [COUNT_W-1:0]         limit;
  logic                       full;
  logic                       minute_ok;
  logic                       sample_ok;
  logic                       res_write;
  status_t                    res_status;
  logic [COUNT_W-1:0]         res_span;
  logic                       walk_start;

  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign limit     = (max_samples > DEPTH_CNT) ? DEPTH_CNT : max_samples;
  assign full      = count >= limit;
  assign minute_ok = !query_minute[MINUTE_W-1] && (query_minute[COUNT_W-1:0] < count);
  assign sample_ok = parse_ok && (sample_value != '0) &&
                     (sample_value >= Q78_LO) && (sample_value <= Q78_HI);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    chain_ctl.op  = OP_HOLD;
    chain_ctl.din = '{ok: sample_ok, value: sample_value};
    count_next    = count;
    res_write     = 1'b0;
    res_status    = ST_LOADED;
    res_span      = '0;
    walk_start    = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_LOAD) begin
            res_write = 1'b1;
            if (full) begin
              res_status = ST_FULL;
            end else begin
              chain_ctl.op = OP_LOAD;
              count_next   = count + COUNT_W'(1);
              res_status   = ST_LOADED;
            end
          end else if (!minute_ok) begin
            res_write  = 1'b1;
            res_status = ST_RANGE;
          end else begin
            walk_start = 1'b1;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        chain_ctl.op = OP_ROTATE;
        if (cyc == LAST_IDX) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        res_write  = 1'b1;
        res_status = corrupt ? ST_CORRUPT : ST_SPAN;
        res_span   = corrupt ? '0 : span_cnt;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_samples <= MAX_RESET;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_samples <= cfg_wr_data;
      end
      count <= count_next;
      if (res_write) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      status       <= res_status;
      span         <= res_span;
      stored_count <= count_next;
    end
    if (walk_start) begin
      cyc     <= '0;
      skip    <= IDX_W'(count - COUNT_W'(1) - query_minute[COUNT_W-1:0]);
      alive   <= 1'b0;
      corrupt <= 1'b0;
      span_cnt <= '0;
    end else if (state == S_WALK) begin
      cyc <= cyc + IDX_W'(1);
      if (cyc == skip) begin
        if (!head.ok) begin
          corrupt <= 1'b1;
        end else begin
          ref_value <= head.value;
          span_cnt  <= COUNT_W'(1);
          alive     <= 1'b1;
        end
      end else if (alive) begin
        if (({1'b0, cyc} < count) && head.ok && (head.value <= ref_value)) begin
          span_cnt <= span_cnt + COUNT_W'(1);
        end else begin
          alive <= 1'b0;
        end
      end
    end
  end

endmodule

@@ hw/rtl/ssqe_checker.sv @@
// Port-level checker for the stock span query engine, bound to the top level.
// Depends on ssqe_pkg and stock_span_query_engine_top.

module ssqe_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [ssqe_pkg::STATUS_W-1:0]        status,
  input logic [ssqe_pkg::COUNT_W-1:0]         span,
  input logic [ssqe_pkg::COUNT_W-1:0]         stored_count
);
  import ssqe_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while a result is stalled");

  a_span_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_SPAN) |-> span == '0)
    else $error("nonzero span on a non-span status");

  a_span_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_SPAN) |-> (span != '0 && span <= stored_count))
    else $error("span outside one to stored count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stored_count <= DEPTH_CNT)
    else $error("stored count above store depth");

endmodule

bind stock_span_query_engine_top ssqe_checker u_ssqe_checker (.*);

@@ tb/stock_span_query_engine_top_test.sv @@
// Self-checking testbench for stock_span_query_engine_top: directed and random
// load and query transactions checked against an in-bench span predictor.
// Depends on ssqe_pkg and stock_span_query_engine_top.

module stock_span_query_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssqe_pkg::*;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct {
    status_t            st;
    logic [COUNT_W-1:0] span;
    logic [COUNT_W-1:0] count;
  } answer_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic kind;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic parse_ok;
  logic signed [MINUTE_W-1:0] query_minute;
  logic out_valid;
  logic out_stall;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] span;
  logic [COUNT_W-1:0] stored_count;

  logic signed [SAMPLE_W-1:0] held_value [STORE_DEPTH];
  bit held_good [STORE_DEPTH];
  int held_count = 0;
  logic [COUNT_W-1:0] sample_limit = MAX_RESET;

  answer_t pending_answers[$];
  int bad_answers = 0;
  int idle_cycles = 0;
  bit idling_on = 1'b1;
  bit hold_request = 1'b0;

  int run_left = 0;
  int run_level = 0;
  bit run_rising = 1'b0;

  stock_span_query_engine_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .sample_value (sample_value),
    .parse_ok     (parse_ok),
    .query_minute (query_minute),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .span         (span),
    .stored_count (stored_count)
  );

  always #10 clk = ~clk;

  function automatic answer_t compute_answer(input logic k,
                                             input logic signed [SAMPLE_W-1:0] v,
                                             input logic pok,
                                             input logic signed [MINUTE_W-1:0] minute);
    answer_t a;
    int limit;
    int idx;
    int run;
    limit = (int'(sample_limit) > STORE_DEPTH) ? STORE_DEPTH : int'(sample_limit);
    a.span = '0;
    if (k == KIND_LOAD) begin
      if (held_count >= limit) begin
        a.st = ST_FULL;
      end else begin
        held_value[held_count] = v;
        held_good[held_count] = pok && (v != 0) && (v >= Q78_LO) && (v <= Q78_HI);
        held_count++;
        a.st = ST_LOADED;
      end
    end else if (minute < 0 || int'(minute) >= held_count) begin
      a.st = ST_RANGE;
    end else begin
      idx = int'(minute);
      if (!held_good[idx]) begin
        a.st = ST_CORRUPT;
      end else begin
        run = 1;
        for (int i = idx; i > 0; i--) begin
          if (!held_good[i-1] || held_value[i-1] > held_value[idx]) break;
          run++;
        end
        a.st = ST_SPAN;
        a.span = COUNT_W'(run);
      end
    end
    a.count = COUNT_W'(held_count);
    return a;
  endfunction

  task automatic send_item(input logic k, input logic signed [SAMPLE_W-1:0] v,
                           input logic pok, input logic signed [MINUTE_W-1:0] m);
    in_valid <= 1'b1;
    kind <= k;
    sample_value <= v;
    parse_ok <= pok;
    query_minute <= m;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_answers.push_back(compute_answer(k, v, pok, m));
  endtask

  task automatic send_load(input logic signed [SAMPLE_W-1:0] v, input logic pok);
    send_item(KIND_LOAD, v, pok, MINUTE_W'($urandom()));
  endtask

  task automatic send_query(input logic signed [MINUTE_W-1:0] m);
    send_item(KIND_QUERY, SAMPLE_W'($urandom()), 1'($urandom()), m);
  endtask

  task automatic sender_gap();
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sample_limit = value;
  endtask

  task automatic next_load_value(output logic signed [SAMPLE_W-1:0] v, output logic pok);
    int pick;
    pick = $urandom_range(0, 99);
    pok = 1'b1;
    if (pick < 8) begin
      v = SAMPLE_W'($urandom());
      pok = 1'($urandom());
    end else if (pick < 12) begin
      v = SAMPLE_W'(int'($urandom_range(0, 51200)) - 25600);
      pok = 1'b0;
    end else begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 80);
        run_rising = ($urandom_range(0, 9) < 7);
        run_level = int'($urandom_range(0, 25600)) - 25600;
      end
      run_left--;
      if (run_rising) run_level = run_level + int'($urandom_range(0, 400));
      else run_level = int'($urandom_range(0, 51200)) - 25600;
      if (run_level > int'(Q78_HI)) run_level = int'(Q78_HI);
      if (run_level == 0) run_level = 1;
      v = SAMPLE_W'(run_level);
    end
  endtask

  task automatic test_limit_zero();
    write_limit('0);
    send_load(SAMPLE_W'(256), 1'b1);
    send_load(SAMPLE_W'(-512), 1'b1);
    send_query(MINUTE_W'(0));
    send_query(MINUTE_W'(-1));
  endtask

  task automatic test_load_extremes();
    write_limit('1);
    send_load(Q78_HI, 1'b1);
    send_load(Q78_LO, 1'b1);
    send_load(SAMPLE_W'(25601), 1'b1);
    send_load(SAMPLE_W'(-25601), 1'b1);
    send_load('0, 1'b1);
    send_load(SAMPLE_W'(32767), 1'b1);
    send_load(SAMPLE_W'(-32768), 1'b1);
    send_load(SAMPLE_W'(256), 1'b0);
    send_load(SAMPLE_W'(-1), 1'b1);
    send_load(SAMPLE_W'(1), 1'b1);
    send_load(SAMPLE_W'(1), 1'b1);
    send_load(SAMPLE_W'(300), 1'b1);
  endtask

  task automatic test_query_cases();
    send_query(MINUTE_W'(-1));
    send_query(MINUTE_W'(2047));
    send_query(MINUTE_W'(held_count));
    send_query(MINUTE_W'(held_count - 1));
    send_query(MINUTE_W'(0));
    send_query(MINUTE_W'(1));
    send_query(MINUTE_W'(2));
    send_query(MINUTE_W'(9));
  endtask

  task automatic test_limit_below_count();
    write_limit(COUNT_W'(5));
    send_load(SAMPLE_W'(512), 1'b1);
    send_query(MINUTE_W'(10));
  endtask

  task automatic test_input_backpressure();
    logic signed [SAMPLE_W-1:0] v;
    logic pok;
    write_limit('1);
    hold_request = 1'b1;
    for (int n = 0; n < 48; n++) begin
      next_load_value(v, pok);
      send_load(v, pok);
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int pick;
    int back;
    int m;
    logic signed [SAMPLE_W-1:0] v;
    logic pok;
    for (int n = 0; n < n_items; n++) begin
      sender_gap();
      pick = $urandom_range(0, 99);
      if (pick < 64) begin
        next_load_value(v, pok);
        send_load(v, pok);
      end else if (pick < 90 && held_count > 0) begin
        if ($urandom_range(0, 1) == 1) begin
          back = $urandom_range(0, (held_count - 1 < 40) ? held_count - 1 : 40);
          m = held_count - 1 - back;
        end else begin
          m = $urandom_range(0, held_count - 1);
        end
        send_query(MINUTE_W'(m));
      end else begin
        case ($urandom_range(0, 2))
          0: m = -1;
          1: m = held_count;
          default: m = $urandom_range(held_count, 2047);
        endcase
        send_query(MINUTE_W'(m));
      end
    end
  endtask

  task automatic test_steady_traffic(input int n_items);
    idling_on = 1'b0;
    write_limit(COUNT_W'($urandom_range(held_count, 2047)));
    test_random_traffic(n_items);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    kind <= KIND_LOAD;
    sample_value <= '0;
    parse_ok <= 1'b0;
    query_minute <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_limit_zero();
    test_load_extremes();
    test_query_cases();
    test_limit_below_count();
    test_input_backpressure();
    write_limit(COUNT_W'(held_count + $urandom_range(30, 90)));
    test_random_traffic(200);
    write_limit(MAX_RESET);
    test_random_traffic(150);
    test_steady_traffic(120);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_answers == 0) begin
      $display("stock_span_query_engine_top_test OK");
    end else begin
      $display("stock_span_query_engine_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idling_on && !rst && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    answer_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_answers.size() == 0) begin
        if (bad_answers < 10)
          $display("Unexpected result transaction: status %0d span %0d count %0d",
                   status, span, stored_count);
        bad_answers++;
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.st || span !== want.span || stored_count !== want.count) begin
          if (bad_answers < 10)
            $display("Mismatch: status %0d/%0d span %0d/%0d count %0d/%0d (expected/actual)",
                     want.st, status, want.span, span, want.count, stored_count);
          bad_answers++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("stock_span_query_engine_top_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
